/* hw/rtl/tsel_pkg.sv */
// tsel_pkg: shared types, codes and field widths for the time-sorted entry list
// used by tsel_cell and time_sorted_entry_list; depends on nothing else
package tsel_pkg;

  localparam int HOUR_BITS        = 5;
  localparam int MIN_BITS         = 6;
  localparam int KEY_BITS         = HOUR_BITS + MIN_BITS;
  localparam int INDEX_BITS       = 3;
  localparam int COUNT_OUT_BITS   = 4;
  localparam int DATA_OUT_BITS    = 32;
  localparam int CAPACITY_DEF     = 8;
  localparam int PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic                  insert;
    logic                  remove;
    logic [INDEX_BITS-1:0] index;
    logic [HOUR_BITS-1:0]  hour;
    logic [MIN_BITS-1:0]   minute;
  } cell_ctrl_t;

endpackage

/* hw/rtl/time_sorted_entry_list.sv */
// time_sorted_entry_list: top level, a row of tsel_cell slots kept in time order
// plus count, decode and output register; depends on tsel_pkg and tsel_cell
// an accepted transaction's result is in the output register in the next cycle
// throughput: one transaction per cycle while in_stall is low; the row's compare and shift select are combinational
// the output register frees the input side whenever the result is taken or absent
// reset: synchronous rst empties the list and drops out_valid; slot contents are not cleared
module time_sorted_entry_list #(
  parameter int CAPACITY     = tsel_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = tsel_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic [tsel_pkg::HOUR_BITS-1:0]     event_hour,
  input  logic [tsel_pkg::MIN_BITS-1:0]      event_minute,
  input  logic [tsel_pkg::DATA_OUT_BITS-1:0] event_payload,
  input  logic [tsel_pkg::INDEX_BITS-1:0]    target_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [tsel_pkg::INDEX_BITS-1:0]    position,
  output logic [tsel_pkg::HOUR_BITS-1:0]     out_hour,
  output logic [tsel_pkg::MIN_BITS-1:0]      out_minute,
  output logic [tsel_pkg::DATA_OUT_BITS-1:0] out_payload,
  output logic [tsel_pkg::COUNT_OUT_BITS-1:0] entry_count
);
  import tsel_pkg::*;

  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  // held entry count, control state
  logic [COUNT_BITS-1:0] held_count;
  logic [COUNT_BITS-1:0] held_count_next;

  logic accept;
  logic full;
  logic index_ok;

  cell_ctrl_t ctrl;
  logic [PAYLOAD_BITS-1:0] new_payload;

  // neighbor chains: element i+1 is what cell i hands to its right
  logic                    sel_chain   [CAPACITY+1];
  logic [HOUR_BITS-1:0]    hour_chain  [CAPACITY+1];
  logic [MIN_BITS-1:0]     min_chain   [CAPACITY+1];
  logic [PAYLOAD_BITS-1:0] pay_chain   [CAPACITY+1];
  logic                    first_flag  [CAPACITY];

  // what cell i takes from its right: cell i+1, zero past the end
  logic [HOUR_BITS-1:0]    right_hour  [CAPACITY];
  logic [MIN_BITS-1:0]     right_min   [CAPACITY];
  logic [PAYLOAD_BITS-1:0] right_pay   [CAPACITY];

  logic [INDEX_BITS-1:0]    insert_at;
  logic [HOUR_BITS-1:0]     read_hour;
  logic [MIN_BITS-1:0]      read_min;
  logic [PAYLOAD_BITS-1:0]  read_pay;

  status_t                  status_next;
  logic [INDEX_BITS-1:0]    position_next;
  logic [HOUR_BITS-1:0]     out_hour_next;
  logic [MIN_BITS-1:0]      out_minute_next;
  logic [DATA_OUT_BITS-1:0] out_payload_next;

  // output register doubles as the skid stage
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full     = int'(held_count) >= CAPACITY;
  assign index_ok = int'(target_index) < int'(held_count);

  // input payload masked to the stored width
  assign new_payload = PAYLOAD_BITS'(event_payload);

  // left of cell zero: never past the insert point
  assign sel_chain[0]  = 1'b0;
  assign hour_chain[0] = '0;
  assign min_chain[0]  = '0;
  assign pay_chain[0]  = '0;

  always_comb begin
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    unique case (op)
      OP_INSERT: ctrl.insert = accept && !full;
      OP_DELETE: ctrl.remove = accept && index_ok;
      default:   ;
    endcase
    ctrl.index  = target_index;
    ctrl.hour   = event_hour;
    ctrl.minute = event_minute;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i + 1 < CAPACITY) begin : g_mid
      assign right_hour[i] = hour_chain[i+2];
      assign right_min[i]  = min_chain[i+2];
      assign right_pay[i]  = pay_chain[i+2];
    end else begin : g_end
      assign right_hour[i] = '0;
      assign right_min[i]  = '0;
      assign right_pay[i]  = '0;
    end

    tsel_cell #(
      .INDEX       (i),
      .PAYLOAD_BITS(PAYLOAD_BITS),
      .COUNT_BITS  (COUNT_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .new_payload  (new_payload),
      .count        (held_count),
      .left_sel     (sel_chain[i]),
      .left_hour    (hour_chain[i]),
      .left_minute  (min_chain[i]),
      .left_payload (pay_chain[i]),
      .right_hour   (right_hour[i]),
      .right_minute (right_min[i]),
      .right_payload(right_pay[i]),
      .sel          (sel_chain[i+1]),
      .first        (first_flag[i]),
      .hour         (hour_chain[i+1]),
      .minute       (min_chain[i+1]),
      .payload      (pay_chain[i+1])
    );
  end

  // insert point is the one cell whose left neighbor is still before it;
  // read picks the slot named by target_index
  always_comb begin
    insert_at = '0;
    read_hour = '0;
    read_min  = '0;
    read_pay  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_flag[i]) begin
        insert_at = insert_at | INDEX_BITS'(i);
      end
      if (i == int'(target_index)) begin
        read_hour = read_hour | hour_chain[i+1];
        read_min  = read_min  | min_chain[i+1];
        read_pay  = read_pay  | pay_chain[i+1];
      end
    end
  end

  always_comb begin
    status_next      = ST_RANGE;
    position_next    = '0;
    out_hour_next    = '0;
    out_minute_next  = '0;
    out_payload_next = '0;
    held_count_next  = held_count;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next     = ST_DONE;
          position_next   = insert_at;
          held_count_next = held_count + COUNT_BITS'(1);
        end
      end
      OP_DELETE: begin
        if (index_ok) begin
          status_next     = ST_DONE;
          position_next   = target_index;
          held_count_next = held_count - COUNT_BITS'(1);
        end
      end
      OP_READ: begin
        if (index_ok) begin
          status_next      = ST_DONE;
          position_next    = target_index;
          out_hour_next    = read_hour;
          out_minute_next  = read_min;
          out_payload_next = DATA_OUT_BITS'(read_pay);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      position    <= position_next;
      out_hour    <= out_hour_next;
      out_minute  <= out_minute_next;
      out_payload <= out_payload_next;
      entry_count <= COUNT_OUT_BITS'(held_count_next);
    end
  end

endmodule

/* hw/rtl/tsel_cell.sv */
// tsel_cell: one slot of the sorted row; compares its entry with the new time
// and shifts up or down with its neighbors; depends on tsel_pkg
module tsel_cell #(
  parameter int INDEX        = 0,
  parameter int PAYLOAD_BITS = tsel_pkg::PAYLOAD_BITS_DEF,
  parameter int COUNT_BITS   = 4
) (
  input  logic                        clk,
  input  tsel_pkg::cell_ctrl_t        ctrl,
  input  logic [PAYLOAD_BITS-1:0]     new_payload,
  input  logic [COUNT_BITS-1:0]       count,
  input  logic                        left_sel,
  input  logic [tsel_pkg::HOUR_BITS-1:0] left_hour,
  input  logic [tsel_pkg::MIN_BITS-1:0]  left_minute,
  input  logic [PAYLOAD_BITS-1:0]     left_payload,
  input  logic [tsel_pkg::HOUR_BITS-1:0] right_hour,
  input  logic [tsel_pkg::MIN_BITS-1:0]  right_minute,
  input  logic [PAYLOAD_BITS-1:0]     right_payload,
  output logic                        sel,
  output logic                        first,
  output logic [tsel_pkg::HOUR_BITS-1:0] hour,
  output logic [tsel_pkg::MIN_BITS-1:0]  minute,
  output logic [PAYLOAD_BITS-1:0]     payload
);
  import tsel_pkg::*;

  logic occupied;
  logic later;

  assign occupied = INDEX < int'(count);
  assign later    = {hour, minute} > {ctrl.hour, ctrl.minute};
  // at or past the insert point: empty slot or a strictly later time
  assign sel      = !occupied || later;
  assign first    = sel && !left_sel;

  always_ff @(posedge clk) begin
    if (ctrl.insert && sel) begin
      if (left_sel) begin
        hour    <= left_hour;
        minute  <= left_minute;
        payload <= left_payload;
      end else begin
        hour    <= ctrl.hour;
        minute  <= ctrl.minute;
        payload <= new_payload;
      end
    end else if (ctrl.remove && (INDEX >= int'(ctrl.index))) begin
      hour    <= right_hour;
      minute  <= right_minute;
      payload <= right_payload;
    end
  end

endmodule
